### rtl/dvp_pkg.sv
// ----------------------------------------------------------------------------
// dvp_pkg
// Shared types and constants of the delta varint polygon decoder.
// ----------------------------------------------------------------------------
package dvp_pkg;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [1:0] KIND_POINT    = 2'd0;
  localparam logic [1:0] KIND_POLY_END = 2'd1;
  localparam logic [1:0] KIND_STRM_END = 2'd2;

  localparam logic [1:0] PST_OK        = 2'd0;
  localparam logic [1:0] PST_OVERSIZE  = 2'd1;
  localparam logic [1:0] PST_LONG      = 2'd2;
  localparam logic [1:0] PST_TRUNC     = 2'd3;

  localparam logic [1:0] SST_DONE      = 2'd0;
  localparam logic [1:0] SST_SHORT     = 2'd1;
  localparam logic [1:0] SST_TOO_MANY  = 2'd2;
  localparam logic [1:0] SST_TRUNC     = 2'd3;

  localparam logic CFG_MAX_POLYGONS = 1'b0;
  localparam logic CFG_MAX_POINTS   = 1'b1;

  localparam logic [15:0] MAX_POLYGONS_RST = 16'd10000;
  localparam logic [15:0] MAX_POINTS_RST   = 16'd15000;

  // Results caused by one input byte: optional point, polygon end, stream end.
  typedef struct packed {
    logic        has_pt;
    logic [15:0] pt_lon;
    logic [15:0] pt_lat;
    logic [15:0] pt_idx;
    logic [15:0] pt_poly;
    logic [15:0] pt_vc;
    logic        has_pe;
    logic [15:0] pe_poly;
    logic [1:0]  pe_status;
    logic        has_se;
    logic [15:0] se_poly;
    logic [1:0]  se_status;
    logic [15:0] end_vc;
  } bundle_t;

  function automatic logic [15:0] zigzag16(input logic [16:0] n);
    zigzag16 = n[16:1] ^ {16{n[0]}};
  endfunction

endpackage

### rtl/dvp_front.sv
// ----------------------------------------------------------------------------
// dvp_front
// Byte parser: tracks stream fields, decodes varint deltas and builds the
// bundle of results caused by each accepted byte.
// ----------------------------------------------------------------------------
module dvp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              q_full,
  output logic              q_push,
  output dvp_pkg::bundle_t  q_wdata
);

  typedef enum logic [2:0] {
    PH_HDR, PH_PCOUNT, PH_FIRST, PH_DLON, PH_DLAT, PH_DONE
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [1:0]   fbc_r, fbc_nxt;
  logic [31:0]  hdr_r, hdr_nxt;
  logic [15:0]  pseen_r, pseen_nxt;
  logic [15:0]  pinp_r, pinp_nxt;
  logic [15:0]  pcnt_r, pcnt_nxt;
  logic [15:0]  rlon_r, rlon_nxt;
  logic [15:0]  rlat_r, rlat_nxt;
  logic [16:0]  vacc_r, vacc_nxt;
  logic [2:0]   vcnt_r, vcnt_nxt;
  logic [15:0]  hlon_r, hlon_nxt;
  logic [15:0]  good_r, good_nxt;
  logic         skip_r, skip_nxt;
  logic [15:0]  max_polygons_r;
  logic [15:0]  max_points_r;

  dvp_pkg::bundle_t bnd;
  logic         in_fire;
  logic         do_emit;
  logic         do_fin;
  logic [1:0]   fin_status;
  logic         fin_good;
  logic [16:0]  vbits;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = in_fire && (bnd.has_pt || bnd.has_pe || bnd.has_se);
  assign q_wdata  = bnd;

  always_comb begin
    unique case (vcnt_r)
      3'd0:    vbits = {10'b0, in_data_byte[6:0]};
      3'd1:    vbits = {3'b0, in_data_byte[6:0], 7'b0};
      3'd2:    vbits = {in_data_byte[2:0], 14'b0};
      default: vbits = '0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    hdr_nxt    = hdr_r;
    pseen_nxt  = pseen_r;
    pinp_nxt   = pinp_r;
    pcnt_nxt   = pcnt_r;
    rlon_nxt   = rlon_r;
    rlat_nxt   = rlat_r;
    vacc_nxt   = vacc_r;
    vcnt_nxt   = vcnt_r;
    hlon_nxt   = hlon_r;
    good_nxt   = good_r;
    skip_nxt   = skip_r;
    bnd        = '0;
    do_emit    = 1'b0;
    do_fin     = 1'b0;
    fin_status = dvp_pkg::PST_OK;
    fin_good   = 1'b0;

    unique case (phase_r)
      PH_HDR: begin
        hdr_nxt = hdr_r | ({24'b0, in_data_byte} << {fbc_r, 3'b000});
        if (fbc_r != 2'd3) begin
          fbc_nxt = fbc_r + 2'd1;
        end else begin
          fbc_nxt = '0;
          if (hdr_nxt > {16'b0, max_polygons_r}) begin
            bnd.has_se    = 1'b1;
            bnd.se_status = dvp_pkg::SST_TOO_MANY;
            phase_nxt     = PH_DONE;
          end else if (hdr_nxt == '0) begin
            bnd.has_se    = 1'b1;
            bnd.se_status = dvp_pkg::SST_DONE;
            phase_nxt     = PH_DONE;
          end else begin
            phase_nxt = PH_PCOUNT;
          end
        end
      end
      PH_PCOUNT: begin
        if (fbc_r == 2'd0) begin
          pinp_nxt = {8'b0, in_data_byte};
          fbc_nxt  = 2'd1;
        end else begin
          pinp_nxt = {in_data_byte, pinp_r[7:0]};
          fbc_nxt  = '0;
          pcnt_nxt = '0;
          if (pinp_nxt == '0) begin
            do_fin = 1'b1;
          end else begin
            skip_nxt  = pinp_nxt > max_points_r;
            phase_nxt = PH_FIRST;
          end
        end
      end
      PH_FIRST: begin
        unique case (fbc_r)
          2'd0:    rlon_nxt = {8'b0, in_data_byte};
          2'd1:    rlon_nxt = {in_data_byte, rlon_r[7:0]};
          2'd2:    rlat_nxt = {8'b0, in_data_byte};
          default: rlat_nxt = {in_data_byte, rlat_r[7:0]};
        endcase
        if (fbc_r != 2'd3) begin
          fbc_nxt = fbc_r + 2'd1;
        end else begin
          fbc_nxt = '0;
          do_emit = 1'b1;
        end
      end
      PH_DLON, PH_DLAT: begin
        vacc_nxt = vacc_r | vbits;
        if (!in_data_byte[7]) begin
          if (phase_r == PH_DLON) begin
            hlon_nxt  = dvp_pkg::zigzag16(vacc_nxt);
            phase_nxt = PH_DLAT;
          end else begin
            rlon_nxt = rlon_r + hlon_r;
            rlat_nxt = rlat_r + dvp_pkg::zigzag16(vacc_nxt);
            do_emit  = 1'b1;
          end
          vacc_nxt = '0;
          vcnt_nxt = '0;
        end else begin
          vcnt_nxt = vcnt_r + 3'd1;
          if (vcnt_nxt >= 3'd5) begin
            do_fin     = 1'b1;
            fin_status = dvp_pkg::PST_LONG;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_emit) begin
      if (!skip_nxt) begin
        bnd.has_pt  = 1'b1;
        bnd.pt_lon  = rlon_nxt;
        bnd.pt_lat  = rlat_nxt;
        bnd.pt_idx  = pcnt_nxt;
        bnd.pt_poly = pseen_nxt;
        bnd.pt_vc   = good_nxt;
      end
      pcnt_nxt = pcnt_nxt + 16'd1;
      if (pcnt_nxt == pinp_nxt) begin
        do_fin     = 1'b1;
        fin_status = skip_nxt ? dvp_pkg::PST_OVERSIZE : dvp_pkg::PST_OK;
        fin_good   = !skip_nxt;
      end else begin
        phase_nxt = PH_DLON;
      end
    end

    if (do_fin) begin
      if (fin_good) begin
        good_nxt = good_nxt + 16'd1;
      end
      bnd.has_pe    = 1'b1;
      bnd.pe_poly   = pseen_nxt;
      bnd.pe_status = fin_status;
      pseen_nxt     = pseen_nxt + 16'd1;
      skip_nxt      = 1'b0;
      vacc_nxt      = '0;
      vcnt_nxt      = '0;
      fbc_nxt       = '0;
      pinp_nxt      = '0;
      if ({16'b0, pseen_nxt} >= hdr_nxt) begin
        bnd.has_se    = 1'b1;
        bnd.se_poly   = pseen_nxt;
        bnd.se_status = dvp_pkg::SST_DONE;
        phase_nxt     = PH_DONE;
      end else begin
        phase_nxt = PH_PCOUNT;
      end
    end

    bnd.end_vc = good_nxt;

    if (in_last_byte) begin
      if (phase_nxt == PH_FIRST || phase_nxt == PH_DLON || phase_nxt == PH_DLAT) begin
        bnd.has_pe    = 1'b1;
        bnd.pe_poly   = pseen_nxt;
        bnd.pe_status = dvp_pkg::PST_TRUNC;
        pseen_nxt     = pseen_nxt + 16'd1;
      end
      if (phase_nxt != PH_DONE) begin
        bnd.has_se    = 1'b1;
        bnd.se_poly   = pseen_nxt;
        bnd.se_status = (phase_nxt == PH_HDR) ? dvp_pkg::SST_SHORT : dvp_pkg::SST_TRUNC;
      end
      phase_nxt = PH_HDR;
      fbc_nxt   = '0;
      hdr_nxt   = '0;
      pseen_nxt = '0;
      pinp_nxt  = '0;
      pcnt_nxt  = '0;
      rlon_nxt  = '0;
      rlat_nxt  = '0;
      vacc_nxt  = '0;
      vcnt_nxt  = '0;
      hlon_nxt  = '0;
      good_nxt  = '0;
      skip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_polygons_r <= dvp_pkg::MAX_POLYGONS_RST;
      max_points_r   <= dvp_pkg::MAX_POINTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dvp_pkg::CFG_MAX_POLYGONS: max_polygons_r <= cfg_wdata;
        dvp_pkg::CFG_MAX_POINTS:   max_points_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      fbc_r   <= '0;
      hdr_r   <= '0;
      pseen_r <= '0;
      pinp_r  <= '0;
      pcnt_r  <= '0;
      rlon_r  <= '0;
      rlat_r  <= '0;
      vacc_r  <= '0;
      vcnt_r  <= '0;
      hlon_r  <= '0;
      good_r  <= '0;
      skip_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      hdr_r   <= hdr_nxt;
      pseen_r <= pseen_nxt;
      pinp_r  <= pinp_nxt;
      pcnt_r  <= pcnt_nxt;
      rlon_r  <= rlon_nxt;
      rlat_r  <= rlat_nxt;
      vacc_r  <= vacc_nxt;
      vcnt_r  <= vcnt_nxt;
      hlon_r  <= hlon_nxt;
      good_r  <= good_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

### rtl/dvp_queue.sv
// ----------------------------------------------------------------------------
// dvp_queue
// Short queue of result bundles between the parser and the emitter.
// ----------------------------------------------------------------------------
module dvp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dvp_pkg::bundle_t  wdata,
  input  logic              pop,
  output dvp_pkg::bundle_t  rdata,
  output logic              full,
  output logic              empty
);

  dvp_pkg::bundle_t                 mem_r [dvp_pkg::QDEPTH];
  logic [dvp_pkg::QPTR_W-1:0]       wptr_r;
  logic [dvp_pkg::QPTR_W-1:0]       rptr_r;
  logic [dvp_pkg::QPTR_W:0]         cnt_r;
  logic [dvp_pkg::QPTR_W:0]         cnt_nxt;

  assign full  = (cnt_r == (dvp_pkg::QPTR_W+1)'(dvp_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/dvp_back.sv
// ----------------------------------------------------------------------------
// dvp_back
// Result emitter: unpacks each bundle into result items, one per cycle while
// the receiver does not stall, into the output register.
// ----------------------------------------------------------------------------
module dvp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dvp_pkg::bundle_t  q_rdata,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [15:0]       out_lon_q,
  output logic [15:0]       out_lat_q,
  output logic [15:0]       out_point_index,
  output logic [15:0]       out_polygon_index,
  output logic [1:0]        out_status,
  output logic [15:0]       out_valid_count,
  output logic              out_last
);

  logic [2:0]  done_r;
  logic [2:0]  rem;
  logic [2:0]  sel;
  logic [2:0]  rem_after;
  logic        load;
  logic        is_last;
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] lon_r;
  logic [15:0] lat_r;
  logic [15:0] pidx_r;
  logic [15:0] poly_r;
  logic [1:0]  status_r;
  logic [15:0] vc_r;
  logic        last_r;

  assign rem       = {q_rdata.has_se, q_rdata.has_pe, q_rdata.has_pt} & ~done_r;
  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign rem_after = rem & ~sel;
  assign is_last   = (rem_after == '0);
  assign q_pop     = load && is_last;

  always_comb begin
    priority if (rem[0]) begin
      sel = 3'b001;
    end else if (rem[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      done_r      <= is_last ? 3'b000 : (done_r | sel);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= is_last;
      unique case (sel)
        3'b001: begin
          kind_r   <= dvp_pkg::KIND_POINT;
          lon_r    <= q_rdata.pt_lon;
          lat_r    <= q_rdata.pt_lat;
          pidx_r   <= q_rdata.pt_idx;
          poly_r   <= q_rdata.pt_poly;
          status_r <= dvp_pkg::PST_OK;
          vc_r     <= q_rdata.pt_vc;
        end
        3'b010: begin
          kind_r   <= dvp_pkg::KIND_POLY_END;
          lon_r    <= '0;
          lat_r    <= '0;
          pidx_r   <= '0;
          poly_r   <= q_rdata.pe_poly;
          status_r <= q_rdata.pe_status;
          vc_r     <= q_rdata.end_vc;
        end
        default: begin
          kind_r   <= dvp_pkg::KIND_STRM_END;
          lon_r    <= '0;
          lat_r    <= '0;
          pidx_r   <= '0;
          poly_r   <= q_rdata.se_poly;
          status_r <= q_rdata.se_status;
          vc_r     <= q_rdata.end_vc;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_lon_q         = lon_r;
  assign out_lat_q         = lat_r;
  assign out_point_index   = pidx_r;
  assign out_polygon_index = poly_r;
  assign out_status        = status_r;
  assign out_valid_count   = vc_r;
  assign out_last          = last_r;

endmodule

### rtl/delta_varint_polygon_decoder_top.sv
// ----------------------------------------------------------------------------
// delta_varint_polygon_decoder_top
// Byte-serial decoder of a delta-coded ZigZag LEB128 polygon stream.
//
// Input channel: one stream byte per item (in_data_byte), in_last_byte on
// the final byte of a stream. Output channel: one result item per transfer,
// a point, a polygon end or a stream end; out_last marks the final result
// caused by one input byte. Points of a polygon whose end status is not ok
// are to be dropped by the receiver.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; a byte that yields two or three results
// sends them one after another, and the four-entry bundle queue absorbs the
// burst. The first result of an accepted byte passes the bundle queue and
// then the output register before it appears on the output.
// Reset: parser returns to the header, limits take 10000 polygons and
// 15000 points. When the receiver stalls, the output register holds, the
// queue fills and in_ready drops once it is full.
// cfg writes take effect at once; the user must issue them only while the block idles, the block does not enforce it.
// ----------------------------------------------------------------------------
module delta_varint_polygon_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_lon_q,
  output logic signed [15:0] out_lat_q,
  output logic [15:0]        out_point_index,
  output logic [15:0]        out_polygon_index,
  output logic [1:0]         out_status,
  output logic [15:0]        out_valid_count,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);

  dvp_pkg::bundle_t q_wdata;
  dvp_pkg::bundle_t q_rdata;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [15:0]      lon_u;
  logic [15:0]      lat_u;

  dvp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  dvp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dvp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_lon_q         (lon_u),
    .out_lat_q         (lat_u),
    .out_point_index   (out_point_index),
    .out_polygon_index (out_polygon_index),
    .out_status        (out_status),
    .out_valid_count   (out_valid_count),
    .out_last          (out_last)
  );

  assign out_lon_q = $signed(lon_u);
  assign out_lat_q = $signed(lat_u);

endmodule
